// ----- design/lkct_pkg.sv -----
// Shared types for the LRU key cache tracker.
`timescale 1ns / 1ps

package lkct_pkg;

  localparam int unsigned KeyW     = 31;
  localparam int unsigned OutSlotW = 4;

  typedef enum logic [0:0] {
    ST_IDLE   = 1'b0,
    ST_UPDATE = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // register the key and the match vector
    logic update;   // rewrite the recency chain and register the result
  } cmd_t;

endpackage

// ----- design/lkct_ctrl.sv -----
// Controller state machine of the LRU key cache tracker.
`timescale 1ns / 1ps

module lkct_ctrl
  import lkct_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o        = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.update  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.capture = start_i;
      end
      ST_UPDATE: begin
        busy_o       = 1'b1;
        cmd_o.update = 1'b1;
      end
      default: busy_o = 1'b0;
    endcase
  end

  // A captured transaction always gets its update cycle next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.update)
    else $error("capture not followed by update");

endmodule

// ----- design/lkct_dpath.sv -----
// Datapath of the LRU key cache tracker: recency chain, key compare, result register.
`timescale 1ns / 1ps

module lkct_dpath
  import lkct_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  logic [KeyW-1:0]     lookup_key_i,
  output logic                result_valid_o,
  output logic                hit_o,
  output logic [OutSlotW-1:0] slot_o,
  output logic                evicted_o,
  output logic [KeyW-1:0]     evicted_key_o
);

  localparam int unsigned SlotW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned OccW  = $clog2(CAPACITY + 1);

  logic [KeyW-1:0]     keys_q  [CAPACITY];
  logic [KeyW-1:0]     keys_d  [CAPACITY];
  logic [SlotW-1:0]    slots_q [CAPACITY];
  logic [SlotW-1:0]    slots_d [CAPACITY];
  logic [OccW-1:0]     occ_q, occ_d;
  logic [KeyW-1:0]     key_q;
  logic [CAPACITY-1:0] match_q, match_d;

  logic                valid_q;
  logic                hit_q, hit_d;
  logic [OutSlotW-1:0] slot_q, slot_d;
  logic                evicted_q, evicted_d;
  logic [KeyW-1:0]     evicted_key_q, evicted_key_d;

  logic                full;
  logic [CAPACITY-1:0] target;
  logic [CAPACITY:0]   upto;
  logic [SlotW-1:0]    slot_hit;
  logic [SlotW-1:0]    slot_sel;
  logic [SlotW+OutSlotW-1:0] slot_wide;

  assign full = (occ_q == OccW'(CAPACITY));

  // Compare the incoming key against every valid chain entry.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_d[i] = (OccW'(i) < occ_q) && (keys_q[i] == lookup_key_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      key_q   <= lookup_key_i;
      match_q <= match_d;
    end
  end

  // One-hot chain position that leaves its place; positions 0..that one shift back.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      target[i] = (occ_q == OccW'(i));
    end
    if (|match_q) begin
      target = match_q;
    end else if (full) begin
      target = {1'b1, {(CAPACITY-1){1'b0}}};
    end
    upto = ({1'b0, target} << 1) - (CAPACITY+1)'(1);
  end

  always_comb begin
    slot_hit = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      slot_hit = slot_hit | (match_q[i] ? slots_q[i] : '0);
    end
    if (|match_q) begin
      slot_sel = slot_hit;
    end else if (full) begin
      slot_sel = slots_q[CAPACITY-1];
    end else begin
      slot_sel = occ_q[SlotW-1:0];
    end
    slot_wide = {{OutSlotW{1'b0}}, slot_sel};
  end

  always_comb begin
    keys_d  = keys_q;
    slots_d = slots_q;
    if (upto[0]) begin
      keys_d[0]  = key_q;
      slots_d[0] = slot_sel;
    end
    for (int i = 1; i < CAPACITY; i++) begin
      if (upto[i]) begin
        keys_d[i]  = keys_q[i-1];
        slots_d[i] = slots_q[i-1];
      end
    end
  end

  always_comb begin
    occ_d = occ_q;
    if (!(|match_q) && !full) occ_d = occ_q + OccW'(1);
    hit_d         = |match_q;
    slot_d        = slot_wide[OutSlotW-1:0];
    evicted_d     = !(|match_q) && full;
    evicted_key_d = evicted_d ? keys_q[CAPACITY-1] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      keys_q        <= keys_d;
      slots_q       <= slots_d;
      hit_q         <= hit_d;
      slot_q        <= slot_d;
      evicted_q     <= evicted_d;
      evicted_key_q <= evicted_key_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.update;
      if (cmd_i.update) occ_q <= occ_d;
    end
  end

  assign result_valid_o = valid_q;
  assign hit_o          = hit_q;
  assign slot_o         = slot_q;
  assign evicted_o      = evicted_q;
  assign evicted_key_o  = evicted_key_q;

  // Keys in the chain are unique, so at most one entry matches.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> $onehot0(match_q))
    else $error("more than one chain entry matched");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(CAPACITY))
    else $error("occupancy above capacity");

  // Occupancy only grows on a miss with room left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (hit_o || evicted_o) |-> $stable(occ_q))
    else $error("occupancy changed on hit or eviction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !evicted_o |-> (evicted_key_o == '0))
    else $error("evicted key not zero without eviction");

endmodule

// ----- design/lru_key_cache_tracker_unit.sv -----
// Top level of the LRU key cache tracker.
`timescale 1ns / 1ps
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+--------------------------------------
//  lookup    | start_i, busy_o           | lookup_key_i
//  result    | result_valid_o (strobe)   | hit_o, slot_o, evicted_o, evicted_key_o
//
//  A transaction is taken when start_i is high and busy_o is low. The key is
//  compared against all chain entries at that edge; the next cycle rewrites
//  the recency chain with busy_o high, so no new lookup is taken until the
//  compare-then-shift sequence of the controller has finished.
//  The result strobe is high for one cycle, the cycle after the update.
//  Reset empties the chain (occupancy zero) at once; no clearing pass.
//  The result receiver cannot stall the block.

module lru_key_cache_tracker_unit
  import lkct_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [KeyW-1:0]     lookup_key_i,
  output logic                result_valid_o,
  output logic                hit_o,
  output logic [OutSlotW-1:0] slot_o,
  output logic                evicted_o,
  output logic [KeyW-1:0]     evicted_key_o
);

  cmd_t cmd;

  lkct_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  lkct_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .lookup_key_i   (lookup_key_i),
    .result_valid_o (result_valid_o),
    .hit_o          (hit_o),
    .slot_o         (slot_o),
    .evicted_o      (evicted_o),
    .evicted_key_o  (evicted_key_o)
  );

endmodule
